/* design/mma_pkg.sv */
// ----------------------------------------------------------------------------
// mma_pkg: shared types and constants
// Transaction payloads, opcodes, register indexes and the control bundle of
// the shared arithmetic unit.
// ----------------------------------------------------------------------------
package mma_pkg;

  localparam int DATA_W = 32;
  localparam int DIM_W  = 4;
  localparam int IDX_W  = 3;
  localparam int OP_W   = 2;
  localparam int CFG_IDX_W = 3;

  localparam logic [OP_W-1:0] OP_WR_A    = 2'd0;
  localparam logic [OP_W-1:0] OP_WR_B    = 2'd1;
  localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_A_ROWS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_A_COLS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_B_ROWS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_B_COLS = 3'd4;

  localparam logic MODE_ADD = 1'b0;
  localparam logic MODE_MUL = 1'b1;

  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]         out_row;
    logic [IDX_W-1:0]         out_col;
    logic signed [DATA_W-1:0] out_value;
    logic                     dim_error;
    logic                     last;
  } out_item_t;

  typedef struct packed {
    logic mul_sel;
    logic prod_en;
    logic acc_clr;
    logic acc_en;
  } alu_ctrl_t;

endpackage

/* design/matrix_multiply_add_unit_top.sv */
// ----------------------------------------------------------------------------
// matrix_multiply_add_unit_top: integer matrix add / multiply engine
// Usage:
//   Input channel (in_valid, in_stall, in_data) carries one transaction per
//   element write (op write A / write B) or a compute request. A write is
//   taken while idle. A compute runs the configured operation and streams
//   the result matrix in row-major order on (out_valid, out_stall, out_data),
//   with last set on the final element. A dimension mismatch or out-of-range
//   dimension gives a single result with dim_error and last set.
//   Each result element takes one pass per term through the shared
//   multiply/add unit (one memory read, one product, one accumulate) and is
//   then handed off; a_cols terms in multiply mode, one term in add mode.
//   in_stall is high from a compute until its last result is taken.
//   A stall on the output holds the result and the sequence in place.
//   Reset clears the sequencer and sets mode to multiply and all dimensions
//   to one; matrix contents are undefined until written. The user must write
//   configuration through cfg_wen/cfg_index/cfg_data while idle (not enforced).
// ----------------------------------------------------------------------------
module matrix_multiply_add_unit_top #(
  parameter int MAX_DIM = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  mma_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output mma_pkg::out_item_t             out_data,
  input  logic                           cfg_wen,
  input  logic [mma_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mma_pkg::DIM_W-1:0]      cfg_data
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_MUL  = 5'b00100,
    S_ACC  = 5'b01000,
    S_WAIT = 5'b10000
  } state_t;

  state_t state;

  logic                       mode;
  logic [mma_pkg::DIM_W-1:0]  a_rows;
  logic [mma_pkg::DIM_W-1:0]  a_cols;
  logic [mma_pkg::DIM_W-1:0]  b_rows;
  logic [mma_pkg::DIM_W-1:0]  b_cols;

  logic [mma_pkg::DIM_W-1:0]  i;
  logic [mma_pkg::DIM_W-1:0]  k;
  logic [mma_pkg::DIM_W-1:0]  l;

  logic [mma_pkg::DATA_W-1:0] mem_a [DEPTH];
  logic [mma_pkg::DATA_W-1:0] mem_b [DEPTH];
  logic [mma_pkg::DATA_W-1:0] a_q;
  logic [mma_pkg::DATA_W-1:0] b_q;
  logic [mma_pkg::DATA_W-1:0] sum;

  logic                       in_acc;
  logic                       out_acc;
  logic                       wr_ok;
  logic [AW-1:0]              wr_addr;
  logic [mma_pkg::DIM_W-1:0]  col_a;
  logic [mma_pkg::DIM_W-1:0]  row_b;
  logic [AW-1:0]              rd_addr_a;
  logic [AW-1:0]              rd_addr_b;
  logic [mma_pkg::DIM_W-1:0]  nr;
  logic [mma_pkg::DIM_W-1:0]  nc;
  logic [mma_pkg::DIM_W-1:0]  nterm;
  logic                       dims_in_range;
  logic                       dims_match;
  logic                       last_elem;
  mma_pkg::alu_ctrl_t         alu_ctrl;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;

  assign wr_ok   = (32'(in_data.row) < MAX_DIM) && (32'(in_data.col) < MAX_DIM);
  assign wr_addr = AW'(32'(in_data.row) * MAX_DIM + 32'(in_data.col));

  assign nr    = a_rows;
  assign nc    = (mode == mma_pkg::MODE_MUL) ? b_cols : a_cols;
  assign nterm = (mode == mma_pkg::MODE_MUL) ? a_cols : mma_pkg::DIM_W'(1);
  assign col_a = (mode == mma_pkg::MODE_MUL) ? l : k;
  assign row_b = (mode == mma_pkg::MODE_MUL) ? l : i;

  assign rd_addr_a = AW'(32'(i) * MAX_DIM + 32'(col_a));
  assign rd_addr_b = AW'(32'(row_b) * MAX_DIM + 32'(k));

  assign dims_in_range = (a_rows != '0) && (32'(a_rows) <= MAX_DIM) &&
                         (a_cols != '0) && (32'(a_cols) <= MAX_DIM) &&
                         (b_rows != '0) && (32'(b_rows) <= MAX_DIM) &&
                         (b_cols != '0) && (32'(b_cols) <= MAX_DIM);
  assign dims_match = (mode == mma_pkg::MODE_MUL) ? (a_cols == b_rows) :
                      ((a_rows == b_rows) && (a_cols == b_cols));

  assign last_elem = ((i + mma_pkg::DIM_W'(1)) == nr) && ((k + mma_pkg::DIM_W'(1)) == nc);

  always_comb begin
    alu_ctrl.mul_sel = mode;
    alu_ctrl.prod_en = (state == S_MUL);
    alu_ctrl.acc_en  = (state == S_ACC);
    alu_ctrl.acc_clr = (state == S_IDLE) || (state == S_WAIT);
  end

  mma_alu u_alu (
    .clk  (clk),
    .ctrl (alu_ctrl),
    .op_a (a_q),
    .op_b (b_q),
    .sum  (sum)
  );

  // element stores
  always_ff @(posedge clk) begin
    if (in_acc && wr_ok && in_data.op == mma_pkg::OP_WR_A) begin
      mem_a[wr_addr] <= in_data.value;
    end
    if (in_acc && wr_ok && in_data.op == mma_pkg::OP_WR_B) begin
      mem_b[wr_addr] <= in_data.value;
    end
    a_q <= mem_a[rd_addr_a];
    b_q <= mem_b[rd_addr_b];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= mma_pkg::MODE_MUL;
      a_rows <= mma_pkg::DIM_W'(1);
      a_cols <= mma_pkg::DIM_W'(1);
      b_rows <= mma_pkg::DIM_W'(1);
      b_cols <= mma_pkg::DIM_W'(1);
    end else if (cfg_wen) begin
      case (cfg_index)
        mma_pkg::REG_MODE:   mode   <= cfg_data[0];
        mma_pkg::REG_A_ROWS: a_rows <= cfg_data;
        mma_pkg::REG_A_COLS: a_cols <= cfg_data;
        mma_pkg::REG_B_ROWS: b_rows <= cfg_data;
        mma_pkg::REG_B_COLS: b_cols <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      i         <= '0;
      k         <= '0;
      l         <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc && in_data.op == mma_pkg::OP_COMPUTE) begin
            i <= '0;
            k <= '0;
            l <= '0;
            if (dims_in_range && dims_match) begin
              state <= S_RD;
            end else begin
              out_data.out_row   <= '0;
              out_data.out_col   <= '0;
              out_data.out_value <= '0;
              out_data.dim_error <= 1'b1;
              out_data.last      <= 1'b1;
              out_valid          <= 1'b1;
              state              <= S_WAIT;
            end
          end
        end
        S_RD: begin
          state <= S_MUL;
        end
        S_MUL: begin
          state <= S_ACC;
        end
        S_ACC: begin
          if ((l + mma_pkg::DIM_W'(1)) < nterm) begin
            l     <= l + mma_pkg::DIM_W'(1);
            state <= S_RD;
          end else begin
            out_data.out_row   <= i[mma_pkg::IDX_W-1:0];
            out_data.out_col   <= k[mma_pkg::IDX_W-1:0];
            out_data.out_value <= sum;
            out_data.dim_error <= 1'b0;
            out_data.last      <= last_elem;
            out_valid          <= 1'b1;
            state              <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (out_acc) begin
            out_valid <= 1'b0;
            l         <= '0;
            if (out_data.last) begin
              state <= S_IDLE;
            end else begin
              state <= S_RD;
              if ((k + mma_pkg::DIM_W'(1)) == nc) begin
                k <= '0;
                i <= i + mma_pkg::DIM_W'(1);
              end else begin
                k <= k + mma_pkg::DIM_W'(1);
              end
            end
          end
        end
        default: begin
          state     <= S_IDLE;
          out_valid <= 1'b0;
        end
      endcase
    end
  end

  a_no_accept_with_result: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !out_valid)
    else $error("input taken while a result is pending");

  a_compute_blocks: assert property (@(posedge clk) disable iff (rst)
    in_acc && in_data.op == mma_pkg::OP_COMPUTE |=> in_stall)
    else $error("compute transaction did not block input");

  a_error_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.dim_error |-> out_data.last)
    else $error("dimension error result without last");

  a_term_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_ACC |-> l < nterm)
    else $error("term counter out of range");

endmodule

/* design/mma_alu.sv */
// ----------------------------------------------------------------------------
// mma_alu: shared multiply/add unit with accumulator
// Forms a registered product or sum of two operands and accumulates it.
// ----------------------------------------------------------------------------
module mma_alu (
  input  logic                        clk,
  input  mma_pkg::alu_ctrl_t          ctrl,
  input  logic [mma_pkg::DATA_W-1:0]  op_a,
  input  logic [mma_pkg::DATA_W-1:0]  op_b,
  output logic [mma_pkg::DATA_W-1:0]  sum
);

  logic [mma_pkg::DATA_W-1:0] prod;
  logic [mma_pkg::DATA_W-1:0] acc;

  assign sum = acc + prod;

  always_ff @(posedge clk) begin
    if (ctrl.prod_en) begin
      prod <= ctrl.mul_sel ? (op_a * op_b) : (op_a + op_b);
    end
    if (ctrl.acc_clr) begin
      acc <= '0;
    end else if (ctrl.acc_en) begin
      acc <= sum;
    end
  end

endmodule

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb: testbench for matrix_multiply_add_unit_top
// Loads elements of A and B, runs add and multiply computes over a range of
// dimension settings, including mismatched and out-of-range shapes, and checks
// every streamed result element against an in-bench matrix calculator.
// Stimulus and result sides idle and stall at random in several phases.
// ----------------------------------------------------------------------------
module tb;

  localparam int MAX_DIM      = 8;
  localparam int CELLS        = MAX_DIM * MAX_DIM;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE       = 16;
  localparam int RANDOM_ITEMS = 140;
  localparam logic [mma_pkg::OP_W-1:0] OP_NONE = 2'd3;

  typedef struct packed {
    logic                      mode;
    logic [mma_pkg::DIM_W-1:0] a_rows;
    logic [mma_pkg::DIM_W-1:0] a_cols;
    logic [mma_pkg::DIM_W-1:0] b_rows;
    logic [mma_pkg::DIM_W-1:0] b_cols;
  } shape_t;

  typedef struct packed {
    bit                 is_cfg;
    shape_t             shape;
    mma_pkg::in_item_t  item;
    bit                 typed;
    mma_pkg::out_item_t want;
  } step_t;

  logic                          clk       = 1'b0;
  logic                          rst       = 1'b1;
  logic                          in_valid  = 1'b0;
  mma_pkg::in_item_t             in_data   = '0;
  logic                          out_stall = 1'b0;
  logic                          cfg_wen   = 1'b0;
  logic [mma_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [mma_pkg::DIM_W-1:0]     cfg_data  = '0;
  logic                          in_stall;
  logic                          out_valid;
  mma_pkg::out_item_t            out_data;

  matrix_multiply_add_unit_top #(
    .MAX_DIM(MAX_DIM)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_wen  (cfg_wen),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #10 clk = ~clk;

  logic [mma_pkg::DATA_W-1:0] mat_a [CELLS];
  logic [mma_pkg::DATA_W-1:0] mat_b [CELLS];
  bit                         a_loaded [CELLS];
  bit                         b_loaded [CELLS];
  shape_t                     shape;
  mma_pkg::out_item_t         pending_elements [$];
  mma_pkg::out_item_t         head;
  int                         errors        = 0;
  int                         src_idle_pct  = 0;
  int                         snk_stall_pct = 0;
  int unsigned                cycle_count   = 0;

  function automatic bit dim_in_range(logic [mma_pkg::DIM_W-1:0] d);
    return d >= 1 && d <= MAX_DIM;
  endfunction

  function automatic bit shape_ok(shape_t g);
    if (!(dim_in_range(g.a_rows) && dim_in_range(g.a_cols) &&
          dim_in_range(g.b_rows) && dim_in_range(g.b_cols)))
      return 1'b0;
    if (g.mode == mma_pkg::MODE_ADD)
      return g.a_rows == g.b_rows && g.a_cols == g.b_cols;
    return g.a_cols == g.b_rows;
  endfunction

  function automatic void apply_matrix_op(mma_pkg::in_item_t it);
    mma_pkg::out_item_t         r;
    logic [mma_pkg::DATA_W-1:0] acc;
    int                         i, k, l, nc, nr, nt;
    case (it.op)
      mma_pkg::OP_WR_A: begin
        mat_a[{it.row, it.col}]    = it.value;
        a_loaded[{it.row, it.col}] = 1'b1;
      end
      mma_pkg::OP_WR_B: begin
        mat_b[{it.row, it.col}]    = it.value;
        b_loaded[{it.row, it.col}] = 1'b1;
      end
      mma_pkg::OP_COMPUTE: begin
        if (!shape_ok(shape)) begin
          r           = '0;
          r.dim_error = 1'b1;
          r.last      = 1'b1;
          pending_elements.push_back(r);
        end else begin
          nr = int'(shape.a_rows);
          nt = int'(shape.a_cols);
          nc = (shape.mode == mma_pkg::MODE_ADD) ? int'(shape.a_cols) : int'(shape.b_cols);
          for (i = 0; i < nr; i++) begin
            for (k = 0; k < nc; k++) begin
              if (shape.mode == mma_pkg::MODE_ADD) begin
                acc = mat_a[i*MAX_DIM+k] + mat_b[i*MAX_DIM+k];
              end else begin
                acc = '0;
                for (l = 0; l < nt; l++)
                  acc = acc + mat_a[i*MAX_DIM+l] * mat_b[l*MAX_DIM+k];
              end
              r.out_row   = mma_pkg::IDX_W'(i);
              r.out_col   = mma_pkg::IDX_W'(k);
              r.out_value = acc;
              r.dim_error = 1'b0;
              r.last      = (i == nr - 1) && (k == nc - 1);
              pending_elements.push_back(r);
            end
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic [mma_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'h0000_0001;
      2: return 32'hFFFF_FFFF;
      3: return 32'h7FFF_FFFF;
      4: return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic step_t cfg_row(logic m, int ar, int ac, int br, int bc);
    step_t s;
    s              = '0;
    s.is_cfg       = 1'b1;
    s.shape.mode   = m;
    s.shape.a_rows = ar[mma_pkg::DIM_W-1:0];
    s.shape.a_cols = ac[mma_pkg::DIM_W-1:0];
    s.shape.b_rows = br[mma_pkg::DIM_W-1:0];
    s.shape.b_cols = bc[mma_pkg::DIM_W-1:0];
    return s;
  endfunction

  function automatic step_t item_row(logic [mma_pkg::OP_W-1:0] op, int r, int c,
                                     logic [mma_pkg::DATA_W-1:0] v);
    step_t s;
    s            = '0;
    s.item.op    = op;
    s.item.row   = r[mma_pkg::IDX_W-1:0];
    s.item.col   = c[mma_pkg::IDX_W-1:0];
    s.item.value = v;
    return s;
  endfunction

  function automatic step_t check_row(logic err, logic [mma_pkg::DATA_W-1:0] v);
    step_t s;
    s                = '0;
    s.item.op        = mma_pkg::OP_COMPUTE;
    s.typed          = 1'b1;
    s.want.out_value = v;
    s.want.dim_error = err;
    s.want.last      = 1'b1;
    return s;
  endfunction

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_elements.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic load_shape(shape_t g);
    logic [mma_pkg::CFG_IDX_W-1:0] idx [5];
    logic [mma_pkg::DIM_W-1:0]     val [5];
    idx = '{mma_pkg::REG_MODE, mma_pkg::REG_A_ROWS, mma_pkg::REG_A_COLS,
            mma_pkg::REG_B_ROWS, mma_pkg::REG_B_COLS};
    val = '{mma_pkg::DIM_W'(g.mode), g.a_rows, g.a_cols, g.b_rows, g.b_cols};
    wait_drained();
    for (int n = 0; n < 5; n++) begin
      cfg_wen   <= 1'b1;
      cfg_index <= idx[n];
      cfg_data  <= val[n];
      @(posedge clk);
    end
    cfg_wen <= 1'b0;
    shape = g;
  endtask

  task automatic send_item(mma_pkg::in_item_t it, bit typed, mma_pkg::out_item_t want);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (typed)
      pending_elements.push_back(want);
    else
      apply_matrix_op(it);
  endtask

  task automatic check_field(string name, logic [mma_pkg::DATA_W-1:0] exp_v,
                             logic [mma_pkg::DATA_W-1:0] got_v);
    if (exp_v !== got_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h",
               $time, name, exp_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_elements.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %p",
                 $time, out_data);
      end else begin
        head = pending_elements.pop_front();
        check_field("out_row",   mma_pkg::DATA_W'(head.out_row),
                    mma_pkg::DATA_W'(out_data.out_row));
        check_field("out_col",   mma_pkg::DATA_W'(head.out_col),
                    mma_pkg::DATA_W'(out_data.out_col));
        check_field("out_value", head.out_value, out_data.out_value);
        check_field("dim_error", mma_pkg::DATA_W'(head.dim_error),
                    mma_pkg::DATA_W'(out_data.dim_error));
        check_field("last",      mma_pkg::DATA_W'(head.last),
                    mma_pkg::DATA_W'(out_data.last));
      end
    end
  end

  always @(posedge clk)
    out_stall <= ($urandom_range(0, 99) < snk_stall_pct);

  always @(posedge clk)
    cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Verification failed");
    $finish;
  end

  initial begin
    step_t             plan [$];
    shape_t            g;
    mma_pkg::in_item_t it;
    mma_pkg::in_item_t job_items [$];
    int                done, job, big_jobs, pick, r, c;

    shape = '{mma_pkg::MODE_MUL, 4'd1, 4'd1, 4'd1, 4'd1};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    plan.push_back(item_row(mma_pkg::OP_WR_A, 0, 0, 32'h7FFF_FFFF));
    plan.push_back(item_row(mma_pkg::OP_WR_B, 0, 0, 32'h8000_0000));
    plan.push_back(check_row(1'b0, 32'h8000_0000));
    plan.push_back(item_row(OP_NONE, 7, 7, 32'hDEAD_BEEF));
    plan.push_back(item_row(mma_pkg::OP_WR_A, 0, 0, 32'hFFFF_FFFF));
    plan.push_back(item_row(mma_pkg::OP_WR_B, 0, 0, 32'hFFFF_FFFF));
    plan.push_back(check_row(1'b0, 32'h0000_0001));
    plan.push_back(cfg_row(mma_pkg::MODE_ADD, 1, 1, 1, 1));
    plan.push_back(item_row(mma_pkg::OP_WR_A, 0, 0, 32'h7FFF_FFFF));
    plan.push_back(item_row(mma_pkg::OP_WR_B, 0, 0, 32'h0000_0001));
    plan.push_back(check_row(1'b0, 32'h8000_0000));
    plan.push_back(item_row(mma_pkg::OP_WR_B, 0, 0, 32'h8000_0000));
    plan.push_back(check_row(1'b0, 32'hFFFF_FFFF));
    plan.push_back(item_row(mma_pkg::OP_WR_A, 7, 7, 32'h8000_0000));
    plan.push_back(item_row(mma_pkg::OP_WR_B, 7, 7, 32'hFFFF_FFFF));
    plan.push_back(cfg_row(mma_pkg::MODE_ADD, 0, 1, 1, 1));
    plan.push_back(check_row(1'b1, 32'h0));
    plan.push_back(cfg_row(mma_pkg::MODE_MUL, 15, 1, 1, 1));
    plan.push_back(check_row(1'b1, 32'h0));
    plan.push_back(cfg_row(mma_pkg::MODE_MUL, 1, 2, 1, 1));
    plan.push_back(check_row(1'b1, 32'h0));
    plan.push_back(cfg_row(mma_pkg::MODE_ADD, 2, 1, 1, 1));
    plan.push_back(check_row(1'b1, 32'h0));
    plan.push_back(cfg_row(mma_pkg::MODE_MUL, 1, 1, 1, 0));
    plan.push_back(check_row(1'b1, 32'h0));
    plan.push_back(cfg_row(mma_pkg::MODE_ADD, 8, 8, 8, 9));
    plan.push_back(check_row(1'b1, 32'h0));
    plan.push_back(cfg_row(mma_pkg::MODE_MUL, 2, 1, 1, 2));
    plan.push_back(item_row(mma_pkg::OP_WR_A, 1, 0, 32'h0000_0003));
    plan.push_back(item_row(mma_pkg::OP_WR_B, 0, 1, 32'hFFFF_FFFE));
    plan.push_back(item_row(mma_pkg::OP_COMPUTE, 0, 0, 32'h0));

    foreach (plan[n]) begin
      if (plan[n].is_cfg)
        load_shape(plan[n].shape);
      else
        send_item(plan[n].item, plan[n].typed, plan[n].want);
    end

    done     = 0;
    job      = 0;
    big_jobs = 0;
    while (done < RANDOM_ITEMS) begin
      case ((job / 3) % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 63; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 63; end
        default: begin src_idle_pct = 11; snk_stall_pct = 11; end
      endcase

      if (job < 2 || $urandom_range(0, 1) == 1) begin
        pick   = (job == 1) ? 1 : int'($urandom_range(0, 9));
        g.mode = 1'($urandom_range(0, 1));
        if (pick == 0) begin
          do begin
            g.a_rows = mma_pkg::DIM_W'($urandom_range(0, 9));
            g.a_cols = mma_pkg::DIM_W'($urandom_range(0, 9));
            g.b_rows = mma_pkg::DIM_W'($urandom_range(0, 9));
            g.b_cols = mma_pkg::DIM_W'($urandom_range(0, 9));
          end while (shape_ok(g));
        end else if (pick == 1 && big_jobs < 1) begin
          g = '{g.mode, 4'd8, 4'd8, 4'd8, 4'd8};
          big_jobs++;
        end else if (pick == 2) begin
          g.mode   = mma_pkg::MODE_MUL;
          g.a_rows = mma_pkg::DIM_W'($urandom_range(1, 8));
          g.a_cols = mma_pkg::DIM_W'(1);
          g.b_rows = mma_pkg::DIM_W'(1);
          g.b_cols = mma_pkg::DIM_W'($urandom_range(1, 8));
        end else begin
          g.a_rows = mma_pkg::DIM_W'($urandom_range(1, 3));
          g.a_cols = mma_pkg::DIM_W'($urandom_range(1, 3));
          g.b_rows = (g.mode == mma_pkg::MODE_ADD) ? g.a_rows : g.a_cols;
          g.b_cols = (g.mode == mma_pkg::MODE_ADD) ? g.a_cols :
                     mma_pkg::DIM_W'($urandom_range(1, 3));
        end
        load_shape(g);
      end

      job_items.delete();
      if (shape_ok(shape)) begin
        for (r = 0; r < int'(shape.a_rows); r++)
          for (c = 0; c < int'(shape.a_cols); c++)
            if (!a_loaded[r*MAX_DIM+c] || $urandom_range(0, 3) == 0)
              job_items.push_back('{mma_pkg::OP_WR_A, mma_pkg::IDX_W'(r),
                                    mma_pkg::IDX_W'(c), pick_value()});
        for (r = 0; r < int'(shape.b_rows); r++)
          for (c = 0; c < int'(shape.b_cols); c++)
            if (!b_loaded[r*MAX_DIM+c] || $urandom_range(0, 3) == 0)
              job_items.push_back('{mma_pkg::OP_WR_B, mma_pkg::IDX_W'(r),
                                    mma_pkg::IDX_W'(c), pick_value()});
      end
      repeat ($urandom_range(0, 2)) begin
        case ($urandom_range(0, 2))
          0: it.op = mma_pkg::OP_WR_A;
          1: it.op = mma_pkg::OP_WR_B;
          default: it.op = OP_NONE;
        endcase
        it.row   = mma_pkg::IDX_W'($urandom_range(0, 7));
        it.col   = mma_pkg::IDX_W'($urandom_range(0, 7));
        it.value = pick_value();
        job_items.insert(int'($urandom_range(0, job_items.size())), it);
      end
      repeat ($urandom_range(1, 2))
        job_items.push_back('{mma_pkg::OP_COMPUTE, mma_pkg::IDX_W'($urandom_range(0, 7)),
                              mma_pkg::IDX_W'($urandom_range(0, 7)), pick_value()});

      foreach (job_items[n]) begin
        if (job_items[n].op == mma_pkg::OP_COMPUTE && $urandom_range(0, 5) == 0)
          wait_drained();
        send_item(job_items[n], 1'b0, '0);
        if (job_items[n].op != OP_NONE)
          done++;
      end
      job++;
    end

    wait_drained();
    if (errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
